### sv/gcrs_pkg.sv
// Package for the garbage-collector root stack: command and status codes, field widths, states.
`default_nettype none
package gcrs_pkg;

  localparam int CMD_W    = 4;
  localparam int HANDLE_W = 32;
  localparam int CNT_W    = 6;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH          = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_IN_FRAME = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP           = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_N         = 4'd3;
  localparam logic [CMD_W-1:0] CMD_OPEN_FRAME    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CLOSE_FRAME   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ADD_GLOBAL    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_REMOVE_GLOBAL = 4'd7;
  localparam logic [CMD_W-1:0] CMD_QUERY         = 4'd8;
  localparam logic [CMD_W-1:0] CMD_ENUMERATE     = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FRAME_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_GLOBAL_FULL = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SEARCH   = 5'b00010,
    S_SHIFT    = 5'b00100,
    S_ENUM     = 5'b01000,
    S_FRAME_LD = 5'b10000
  } state_t;

endpackage
`default_nettype wire

### sv/gc_root_stack_with_frames.sv
// Top level of the garbage-collector root stack with frames and a global root set.
// Push, push in frame, pop, pop_n, open frame, add of handle 0, unused codes and an empty
//   enumerate answer from the idle state; close frame also reloads the count when a frame stays open.
// Add, remove and query scan the global RAM from position 0 up to a hit or the end of the set;
//   remove then moves each later entry down one place.
// Enumerate streams its results one per cycle once the first RAM read returns.
// Reset (synchronous, rst_n low) empties all three stores; the receiver cannot stall.
`default_nettype none
module gc_root_stack_with_frames #(
  parameter int STACK_DEPTH  = 32,
  parameter int FRAME_DEPTH  = 16,
  parameter int GLOBAL_SLOTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [gcrs_pkg::CMD_W-1:0]    in_command,
  input  wire logic [gcrs_pkg::HANDLE_W-1:0] in_handle,
  input  wire logic [gcrs_pkg::CNT_W-1:0]    in_pop_count,
  output logic                               out_valid,
  output logic [gcrs_pkg::HANDLE_W-1:0]      out_handle_out,
  output logic                               out_entry_valid,
  output logic                               out_found,
  output logic [gcrs_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_last
);

  // Level widths hold the depth itself; address widths index the RAMs.
  localparam int RW  = $clog2(STACK_DEPTH + 1);
  localparam int RAW = $clog2(STACK_DEPTH);
  localparam int FW  = $clog2(FRAME_DEPTH + 1);
  localparam int FAW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int GW  = $clog2(GLOBAL_SLOTS + 1);
  localparam int GAW = (GLOBAL_SLOTS > 1) ? $clog2(GLOBAL_SLOTS) : 1;
  localparam int DW  = (RW > gcrs_pkg::CNT_W) ? RW : gcrs_pkg::CNT_W;
  localparam int HW  = gcrs_pkg::HANDLE_W;

  gcrs_pkg::state_t state_r, state_nxt;

  logic [RW-1:0] root_level_r, root_level_nxt;
  logic [FW-1:0] frame_level_r, frame_level_nxt;
  logic [GW-1:0] global_level_r, global_level_nxt;

  // Count of the open frame lives in a register; frames below it sit in the frame RAM.
  // It saturates at STACK_DEPTH, which drops the same roots as any larger count.
  logic [RW-1:0] top_size_r, top_size_nxt;

  logic [gcrs_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [HW-1:0]              h_r, h_nxt;

  // Shared walk pointer: search read pointer, shift read pointer, enumerate countdown.
  logic [GW-1:0] ptr_r, ptr_nxt;
  logic          pv_r, pv_nxt;      // a RAM read is in flight
  logic          psrc_r, psrc_nxt;  // in-flight enumerate read is from the global RAM
  logic          plast_r, plast_nxt;
  logic [RW-1:0] eidx_r, eidx_nxt;

  logic                          ov_r, ov_nxt;
  logic [HW-1:0]                 oh_r, oh_nxt;
  logic                          oev_r, oev_nxt;
  logic                          ofd_r, ofd_nxt;
  logic [gcrs_pkg::STATUS_W-1:0] ost_r, ost_nxt;
  logic                          olast_r, olast_nxt;

  logic           r_we;
  logic [RAW-1:0] r_waddr, r_raddr;
  logic [HW-1:0]  r_rdata;

  logic           f_we;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [RW-1:0]  f_rdata;

  logic           g_we;
  logic [GAW-1:0] g_waddr, g_raddr;
  logic [HW-1:0]  g_wdata, g_rdata;

  logic [GW-1:0] ptr_m1, ptr_m2;
  logic [FW-1:0] fl_m1, fl_m2;
  logic [DW-1:0] lvl_ext, cnt_ext, top_ext;
  logic          accept, match;

  gcrs_ram #(.WIDTH(HW), .DEPTH(STACK_DEPTH)) u_root_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (in_handle),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  gcrs_ram #(.WIDTH(RW), .DEPTH(FRAME_DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (top_size_r),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  gcrs_ram #(.WIDTH(HW), .DEPTH(GLOBAL_SLOTS)) u_global_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  assign busy   = (state_r != gcrs_pkg::S_IDLE);
  assign accept = start && !busy;

  assign ptr_m1  = ptr_r - GW'(1);
  assign ptr_m2  = ptr_r - GW'(2);
  assign fl_m1   = frame_level_r - FW'(1);
  assign fl_m2   = frame_level_r - FW'(2);
  assign lvl_ext = DW'(root_level_r);
  assign cnt_ext = DW'(in_pop_count);
  assign top_ext = DW'(top_size_r);

  // The single comparator of the global scan.
  assign match = pv_r && (g_rdata == h_r);

  assign r_waddr = root_level_r[RAW-1:0];
  assign r_raddr = eidx_r[RAW-1:0];
  assign f_waddr = fl_m1[FAW-1:0];
  assign f_raddr = fl_m2[FAW-1:0];

  always_comb begin
    state_nxt        = state_r;
    root_level_nxt   = root_level_r;
    frame_level_nxt  = frame_level_r;
    global_level_nxt = global_level_r;
    top_size_nxt     = top_size_r;
    cmd_nxt          = cmd_r;
    h_nxt            = h_r;
    ptr_nxt          = ptr_r;
    pv_nxt           = pv_r;
    psrc_nxt         = psrc_r;
    plast_nxt        = plast_r;
    eidx_nxt         = eidx_r;

    ov_nxt    = 1'b0;
    oh_nxt    = oh_r;
    oev_nxt   = oev_r;
    ofd_nxt   = ofd_r;
    ost_nxt   = ost_r;
    olast_nxt = olast_r;

    r_we    = 1'b0;
    f_we    = 1'b0;
    g_we    = 1'b0;
    g_waddr = global_level_r[GAW-1:0];
    g_wdata = h_r;
    g_raddr = ptr_r[GAW-1:0];

    case (state_r)
      gcrs_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_command;
          h_nxt     = in_handle;
          ov_nxt    = 1'b1;
          oh_nxt    = '0;
          oev_nxt   = 1'b0;
          ofd_nxt   = 1'b0;
          ost_nxt   = gcrs_pkg::ST_OK;
          olast_nxt = 1'b1;
          case (in_command)
            gcrs_pkg::CMD_PUSH, gcrs_pkg::CMD_PUSH_IN_FRAME: begin
              oh_nxt = in_handle;
              if ((in_command == gcrs_pkg::CMD_PUSH_IN_FRAME) && (frame_level_r == '0)) begin
                ost_nxt = gcrs_pkg::ST_NO_FRAME;
              end else if (root_level_r >= RW'(STACK_DEPTH)) begin
                ost_nxt = gcrs_pkg::ST_STACK_FULL;
              end else begin
                r_we           = 1'b1;
                root_level_nxt = root_level_r + RW'(1);
                oev_nxt        = 1'b1;
                if ((in_command == gcrs_pkg::CMD_PUSH_IN_FRAME) &&
                    (top_size_r != RW'(STACK_DEPTH))) begin
                  top_size_nxt = top_size_r + RW'(1);
                end
              end
            end
            gcrs_pkg::CMD_POP: begin
              if (root_level_r != '0) begin
                root_level_nxt = root_level_r - RW'(1);
              end
            end
            gcrs_pkg::CMD_POP_N: begin
              // Clamp at zero.
              root_level_nxt = (cnt_ext >= lvl_ext) ? '0 : RW'(lvl_ext - cnt_ext);
            end
            gcrs_pkg::CMD_OPEN_FRAME: begin
              if (frame_level_r >= FW'(FRAME_DEPTH)) begin
                ost_nxt = gcrs_pkg::ST_FRAME_FULL;
              end else begin
                // Spill the open frame's count below the new one.
                f_we            = (frame_level_r != '0);
                top_size_nxt    = '0;
                frame_level_nxt = frame_level_r + FW'(1);
              end
            end
            gcrs_pkg::CMD_CLOSE_FRAME: begin
              if (frame_level_r == '0) begin
                ost_nxt = gcrs_pkg::ST_NO_FRAME;
              end else begin
                root_level_nxt  = (top_ext >= lvl_ext) ? '0 : RW'(lvl_ext - top_ext);
                frame_level_nxt = fl_m1;
                // Reload the count of the frame that becomes open.
                if (fl_m1 != '0) begin
                  state_nxt = gcrs_pkg::S_FRAME_LD;
                end
              end
            end
            gcrs_pkg::CMD_ADD_GLOBAL, gcrs_pkg::CMD_REMOVE_GLOBAL, gcrs_pkg::CMD_QUERY: begin
              if ((in_command == gcrs_pkg::CMD_ADD_GLOBAL) && (in_handle == '0)) begin
                // Handle zero is never made global: answer at once.
                oh_nxt = '0;
              end else begin
                ov_nxt    = 1'b0;
                ptr_nxt   = '0;
                pv_nxt    = 1'b0;
                state_nxt = gcrs_pkg::S_SEARCH;
              end
            end
            gcrs_pkg::CMD_ENUMERATE: begin
              if ((global_level_r != '0) || (root_level_r != '0)) begin
                ov_nxt    = 1'b0;
                ptr_nxt   = global_level_r;
                eidx_nxt  = '0;
                pv_nxt    = 1'b0;
                state_nxt = gcrs_pkg::S_ENUM;
              end
            end
            default: begin
            end
          endcase
        end
      end

      gcrs_pkg::S_SEARCH: begin
        oh_nxt    = h_r;
        ofd_nxt   = 1'b0;
        ost_nxt   = gcrs_pkg::ST_OK;
        olast_nxt = 1'b1;
        if (match) begin
          // Hit at ptr_r - 1.
          case (cmd_r)
            gcrs_pkg::CMD_REMOVE_GLOBAL: begin
              // Shift starts reading at position + 1, which is ptr_r.
              pv_nxt    = 1'b0;
              state_nxt = gcrs_pkg::S_SHIFT;
            end
            gcrs_pkg::CMD_QUERY: begin
              ov_nxt    = 1'b1;
              oev_nxt   = 1'b1;
              ofd_nxt   = 1'b1;
              state_nxt = gcrs_pkg::S_IDLE;
            end
            default: begin
              ov_nxt    = 1'b1;
              oev_nxt   = 1'b1;
              state_nxt = gcrs_pkg::S_IDLE;
            end
          endcase
        end else if (ptr_r < global_level_r) begin
          ptr_nxt = ptr_r + GW'(1);
          pv_nxt  = 1'b1;
        end else if (pv_r) begin
          pv_nxt = 1'b0;
        end else begin
          // Scan exhausted: handle is absent.
          ov_nxt    = 1'b1;
          oev_nxt   = 1'b0;
          state_nxt = gcrs_pkg::S_IDLE;
          if (cmd_r == gcrs_pkg::CMD_ADD_GLOBAL) begin
            if (global_level_r >= GW'(GLOBAL_SLOTS)) begin
              ost_nxt = gcrs_pkg::ST_GLOBAL_FULL;
            end else begin
              g_we             = 1'b1;
              global_level_nxt = global_level_r + GW'(1);
              oev_nxt          = 1'b1;
            end
          end
        end
      end

      gcrs_pkg::S_SHIFT: begin
        // Move each later entry down one place, one per cycle.
        g_waddr = ptr_m2[GAW-1:0];
        g_wdata = g_rdata;
        g_we    = pv_r;
        if (ptr_r < global_level_r) begin
          ptr_nxt = ptr_r + GW'(1);
          pv_nxt  = 1'b1;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            global_level_nxt = global_level_r - GW'(1);
            ov_nxt           = 1'b1;
            oh_nxt           = h_r;
            oev_nxt          = 1'b1;
            ofd_nxt          = 1'b0;
            ost_nxt          = gcrs_pkg::ST_OK;
            olast_nxt        = 1'b1;
            state_nxt        = gcrs_pkg::S_IDLE;
          end
        end
      end

      gcrs_pkg::S_ENUM: begin
        // Emit the entry read last cycle, issue the next read.
        g_raddr = ptr_m1[GAW-1:0];
        if (pv_r) begin
          ov_nxt    = 1'b1;
          oh_nxt    = psrc_r ? g_rdata : r_rdata;
          oev_nxt   = 1'b1;
          ofd_nxt   = 1'b0;
          ost_nxt   = gcrs_pkg::ST_OK;
          olast_nxt = plast_r;
        end
        if (ptr_r != '0) begin
          ptr_nxt   = ptr_m1;
          pv_nxt    = 1'b1;
          psrc_nxt  = 1'b1;
          plast_nxt = (ptr_r == GW'(1)) && (root_level_r == '0);
        end else if (eidx_r < root_level_r) begin
          eidx_nxt  = eidx_r + RW'(1);
          pv_nxt    = 1'b1;
          psrc_nxt  = 1'b0;
          plast_nxt = ((eidx_r + RW'(1)) == root_level_r);
        end else begin
          pv_nxt    = 1'b0;
          state_nxt = gcrs_pkg::S_IDLE;
        end
      end

      gcrs_pkg::S_FRAME_LD: begin
        top_size_nxt = f_rdata;
        state_nxt    = gcrs_pkg::S_IDLE;
      end

      default: begin
        state_nxt = gcrs_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= gcrs_pkg::S_IDLE;
      root_level_r   <= '0;
      frame_level_r  <= '0;
      global_level_r <= '0;
      ov_r           <= 1'b0;
      pv_r           <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      root_level_r   <= root_level_nxt;
      frame_level_r  <= frame_level_nxt;
      global_level_r <= global_level_nxt;
      ov_r           <= ov_nxt;
      pv_r           <= pv_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    top_size_r <= top_size_nxt;
    cmd_r      <= cmd_nxt;
    h_r        <= h_nxt;
    ptr_r      <= ptr_nxt;
    psrc_r     <= psrc_nxt;
    plast_r    <= plast_nxt;
    eidx_r     <= eidx_nxt;
    oh_r       <= oh_nxt;
    oev_r      <= oev_nxt;
    ofd_r      <= ofd_nxt;
    ost_r      <= ost_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_handle_out  = oh_r;
  assign out_entry_valid = oev_r;
  assign out_found       = ofd_r;
  assign out_status      = ost_r;
  assign out_last        = olast_r;

endmodule
`default_nettype wire

### sv/gcrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gcrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
